// File: design/node_table_with_aging_and_rate_limit_assert.svh
// Assertion macros for the node table.
`ifndef NODE_TABLE_WITH_AGING_AND_RATE_LIMIT_ASSERT_SVH
`define NODE_TABLE_WITH_AGING_AND_RATE_LIMIT_ASSERT_SVH

// implication checked every edge outside reset
`define NT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define NT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/ntar_pkg.sv
// ---------------------------------------------------------------------------
// ntar_pkg
// Types and constants of the node table.
// ---------------------------------------------------------------------------
`default_nettype none
package ntar_pkg;
  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [2:0] ACT_UPDATE = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_SWEEP  = 3'd2;
  localparam logic [2:0] ACT_ALERT  = 3'd3;
  localparam logic [2:0] ACT_DUMP   = 3'd4;

  localparam logic [3:0] ST_UPDATED   = 4'd0;
  localparam logic [3:0] ST_INSERTED  = 4'd1;
  localparam logic [3:0] ST_FULL      = 4'd2;
  localparam logic [3:0] ST_ALLOWED   = 4'd3;
  localparam logic [3:0] ST_THROTTLED = 4'd4;
  localparam logic [3:0] ST_UNKNOWN   = 4'd5;
  localparam logic [3:0] ST_TICKED    = 4'd6;
  localparam logic [3:0] ST_REMOVED   = 4'd7;
  localparam logic [3:0] ST_SWEEPDONE = 4'd8;
  localparam logic [3:0] ST_DUMPENT   = 4'd9;
  localparam logic [3:0] ST_DUMPDONE  = 4'd10;

  localparam logic [0:0] REG_TIMEOUT  = 1'd0;
  localparam logic [0:0] REG_INTERVAL = 1'd1;

  localparam logic [10:0] SCORE_WEIGHT = 11'd2000;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] node_id;
    logic [15:0] light_level;
    logic [7:0]  motion;
    logic        node_role;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] result_id;
    logic        result_role;
    logic [15:0] result_light;
    logic [7:0]  result_motion;
    logic [19:0] score;
    logic        last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input word
    logic             rd;        // read entry at idx
    logic [IDX_W-1:0] idx;
    logic             eval;      // evaluate registered read data
    logic             wr_upd;    // refresh slot at hit index
    logic             wr_ins;    // insert at free index
    logic             wr_alert;  // stamp alert at hit index
    logic             clr;       // clear valid at read index
    logic             tick;
    logic             emit;
    logic [3:0]       status;
    logic             use_entry; // take id etc. from read entry
    logic             dump;      // include dump fields
    logic             last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic       valid;      // evaluated entry valid
    logic       match;      // evaluated entry matches id
    logic       aged;       // evaluated entry is past timeout
    logic       alert_ok;   // evaluated entry may alert
    logic       hit;        // a match was found so far
    logic       free;       // a free slot was found so far
    logic       hit_ok;     // alert allowed at hit slot
    logic       out_busy;   // output register full and not taken
  } stat_t;
endpackage
`default_nettype wire

// File: design/ntar_stream_if.sv
// ---------------------------------------------------------------------------
// ntar_stream_if
// Valid/ready channel carrying one word.
// ---------------------------------------------------------------------------
`default_nettype none
interface ntar_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/ntar_ctrl.sv
// ---------------------------------------------------------------------------
// ntar_ctrl
// Sequencer: scans the table one entry a cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none
module ntar_ctrl
  import ntar_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DONE = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] rcnt_q, rcnt_d;   // read address
  logic             ev_q, ev_d;       // read data pending

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    rcnt_d  = rcnt_q;
    ev_d    = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          rcnt_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat_i.out_busy) begin
          if (ev_q) begin
            cmd_o.eval = 1'b1;
            if (stat_i.action == ACT_SWEEP && stat_i.valid && stat_i.aged) begin
              cmd_o.clr = 1'b1; cmd_o.emit = 1'b1; cmd_o.status = ST_REMOVED;
              cmd_o.use_entry = 1'b1;
            end
            if (stat_i.action == ACT_DUMP && stat_i.valid) begin
              cmd_o.emit = 1'b1; cmd_o.status = ST_DUMPENT;
              cmd_o.use_entry = 1'b1; cmd_o.dump = 1'b1;
            end
          end
          if (stat_i.action == ACT_TICK || stat_i.action > ACT_DUMP) begin
            state_d = S_DONE;
          end else if (rcnt_q < CNT_W'(ENTRIES)) begin
            cmd_o.rd = 1'b1;
            cmd_o.idx = rcnt_q[IDX_W-1:0];
            ev_d   = 1'b1;
            rcnt_d = rcnt_q + 1'b1;
          end else if (!ev_q) begin
            state_d = S_DONE;
          end
        end else begin
          ev_d = ev_q;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          state_d = S_FIN;
          cmd_o.last = 1'b1;
          priority case (stat_i.action)
            ACT_UPDATE: begin
              cmd_o.emit = 1'b1;
              if (stat_i.hit) begin
                cmd_o.wr_upd = 1'b1; cmd_o.status = ST_UPDATED;
              end else if (stat_i.free) begin
                cmd_o.wr_ins = 1'b1; cmd_o.status = ST_INSERTED;
              end else begin
                cmd_o.status = ST_FULL;
              end
            end
            ACT_TICK: begin
              cmd_o.emit = 1'b1; cmd_o.tick = 1'b1; cmd_o.status = ST_TICKED;
            end
            ACT_SWEEP: begin
              cmd_o.emit = 1'b1; cmd_o.status = ST_SWEEPDONE;
            end
            ACT_ALERT: begin
              cmd_o.emit = 1'b1;
              if (!stat_i.hit) begin
                cmd_o.status = ST_UNKNOWN;
              end else if (stat_i.hit_ok) begin
                cmd_o.wr_alert = 1'b1; cmd_o.status = ST_ALLOWED;
              end else begin
                cmd_o.status = ST_THROTTLED;
              end
            end
            ACT_DUMP: begin
              cmd_o.emit = 1'b1; cmd_o.status = ST_DUMPDONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rcnt_q  <= '0;
      ev_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
      ev_q    <= ev_d;
    end
  end
endmodule
`default_nettype wire

// File: design/ntar_datapath.sv
// ---------------------------------------------------------------------------
// ntar_datapath
// Entry memory, valid bits, seconds counter, compare logic, output register.
// ---------------------------------------------------------------------------
`default_nettype none
module ntar_datapath
  import ntar_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_word_t    in_i,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire logic [15:0] timeout_i,
  input  wire logic [15:0] interval_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_o
);
  typedef struct packed {
    logic [31:0] id;
    logic        role;
    logic [15:0] light;
    logic [7:0]  motion;
    logic [31:0] seen;
    logic [31:0] atime;
    logic        alerted;
  } entry_t;

  entry_t           mem [ENTRIES];
  entry_t           rd_q;
  logic [IDX_W-1:0] ridx_q;
  logic [ENTRIES-1:0] valid_q;
  logic [31:0]      now_q;
  in_word_t         in_q;
  logic             hit_q, free_q, hit_ok_q;
  logic [IDX_W-1:0] hidx_q, fidx_q;
  out_word_t        out_q;
  logic             ov_q;
  logic             ev_valid, ev_match, ev_aged, ev_ok;
  logic [31:0]      age, adist;
  logic [19:0]      sc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;

  assign age      = now_q - rd_q.seen;
  assign adist    = now_q - rd_q.atime;
  assign ev_valid = valid_q[ridx_q];
  assign ev_match = ev_valid && rd_q.id == in_q.node_id;
  assign ev_aged  = age > {16'd0, timeout_i};
  assign ev_ok    = !rd_q.alerted || adist >= {16'd0, interval_i};
  assign sc       = 20'(rd_q.light) + 20'(rd_q.motion) * 20'(SCORE_WEIGHT);

  always_comb begin
    stat_o = '0;
    stat_o.action   = in_q.action;
    stat_o.valid    = ev_valid;
    stat_o.match    = ev_match;
    stat_o.aged     = ev_aged;
    stat_o.alert_ok = ev_ok;
    stat_o.hit      = hit_q;
    stat_o.free     = free_q;
    stat_o.hit_ok   = hit_ok_q;
    stat_o.out_busy = ov_q && !out_ready_i;
  end

  always_comb begin
    wr_en   = cmd_i.wr_upd || cmd_i.wr_ins || cmd_i.wr_alert;
    wr_idx  = cmd_i.wr_ins ? fidx_q : hidx_q;
    wr_data = '0;
    wr_data.id      = in_q.node_id;
    wr_data.role    = in_q.node_role;
    wr_data.light   = in_q.light_level;
    wr_data.motion  = in_q.motion;
    wr_data.seen    = now_q;
  end

  // per-field writes keep the other fields of the entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= mem[cmd_i.idx];
    end
    if (wr_en) begin
      if (cmd_i.wr_ins) begin
        mem[wr_idx] <= wr_data;
      end else if (cmd_i.wr_upd) begin
        mem[wr_idx].role   <= in_q.node_role;
        mem[wr_idx].light  <= in_q.light_level;
        mem[wr_idx].motion <= in_q.motion;
        mem[wr_idx].seen   <= now_q;
      end else begin
        mem[wr_idx].atime   <= now_q;
        mem[wr_idx].alerted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      now_q    <= '0;
      ridx_q   <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      hit_ok_q <= 1'b0;
      hidx_q   <= '0;
      fidx_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.rd) ridx_q <= cmd_i.idx;
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (cmd_i.eval) begin
        if (ev_match && !hit_q) begin
          hit_q    <= 1'b1;
          hidx_q   <= ridx_q;
          hit_ok_q <= ev_ok;
        end
        if (!ev_valid && !free_q) begin
          free_q <= 1'b1;
          fidx_q <= ridx_q;
        end
      end
      if (cmd_i.clr) valid_q[ridx_q] <= 1'b0;
      if (cmd_i.wr_ins) valid_q[fidx_q] <= 1'b1;
      if (cmd_i.tick) now_q <= now_q + 32'd1;
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status        <= cmd_i.status;
      out_q.result_id     <= cmd_i.use_entry ? rd_q.id :
                             (cmd_i.status == ST_TICKED || cmd_i.status == ST_SWEEPDONE ||
                              cmd_i.status == ST_DUMPDONE) ? 32'd0 : in_q.node_id;
      out_q.result_role   <= cmd_i.dump ? rd_q.role : 1'b0;
      out_q.result_light  <= cmd_i.dump ? rd_q.light : 16'd0;
      out_q.result_motion <= cmd_i.dump ? rd_q.motion : 8'd0;
      out_q.score         <= cmd_i.dump ? sc : 20'd0;
      out_q.last          <= cmd_i.last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;
endmodule
`default_nettype wire

// File: design/node_table_with_aging_and_rate_limit.sv
// Sequence: tick and unused actions skip the table scan; table actions read
// all 32 entries in turn, evaluate the last read, drain, then decide.
// A new word is accepted only once the previous one is finished; each emitted
// word that finds the output register full stalls the sequencer.
// Reset: asynchronous, clears valid bits, seconds counter and control state.
// ---------------------------------------------------------------------------
// node_table_with_aging_and_rate_limit
// Aging node table with per-node alert throttle and APB config.
// ---------------------------------------------------------------------------
`default_nettype none
`include "node_table_with_aging_and_rate_limit_assert.svh"
module node_table_with_aging_and_rate_limit
  import ntar_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ntar_stream_if.sink      in_if,
  ntar_stream_if.source    out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [15:0] timeout_q, interval_q;
  cmd_t        cmd;
  stat_t       stat;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= 16'd30;
      interval_q <= 16'd10;
    end else if (wr && paddr[1:0] == 2'b00 && !paddr[2]) begin
      timeout_q <= pwdata[15:0];
    end else if (wr && paddr[1:0] == 2'b00 && paddr[2] == REG_INTERVAL) begin
      interval_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : {16'd0, interval_q};
    end
  end

  ntar_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ntar_datapath u_dp (
    .clk_i, .rst_ni,
    .in_i        (in_if.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .timeout_i   (timeout_q),
    .interval_i  (interval_q),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_o       (out_if.data)
  );

  `NT_ASSERT_IMP(a_emit_free, cmd.emit, !stat.out_busy)
  `NT_ASSERT_NEXT(a_load_busy, in_if.valid && in_if.ready, !in_if.ready)
  `NT_ASSERT_IMP(a_one_write, cmd.wr_ins, !cmd.wr_upd && !cmd.wr_alert)
endmodule
`default_nettype wire

// File: bench/node_table_with_aging_and_rate_limit_tb.sv
// ---------------------------------------------------------------------------
// node_table_with_aging_and_rate_limit_tb
// Self-checking bench for the aging node table: a directed table of words
// followed by random traffic of every action, unused codes included. Every word the
// block returns is compared against an in-bench model of the table, with
// random gaps on the input side and random stalls on the output side.
// ---------------------------------------------------------------------------
`default_nettype none
module node_table_with_aging_and_rate_limit_tb;
  import ntar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT = 2000000;
  localparam int unsigned SETTLE = 60;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] node_id;
    logic [15:0] light;
    logic [7:0]  motion;
    logic        role;
    logic        has_exp;
    logic [3:0]  exp_status;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ntar_stream_if #(.T(in_word_t)) in_if ();
  ntar_stream_if #(.T(out_word_t)) out_if ();

  node_table_with_aging_and_rate_limit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // model state
  logic [15:0] m_timeout;
  logic [15:0] m_interval;
  logic [31:0] m_now;
  logic        m_valid   [ENTRIES];
  logic [31:0] m_id      [ENTRIES];
  logic        m_role    [ENTRIES];
  logic [15:0] m_light   [ENTRIES];
  logic [7:0]  m_motion  [ENTRIES];
  logic [31:0] m_seen    [ENTRIES];
  logic [31:0] m_alert_t [ENTRIES];
  logic        m_alerted [ENTRIES];

  out_word_t pending_words[$];
  logic [3:0] forced_status[$];
  logic forced_valid[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  logic [31:0] known_ids[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, words_out);
  endtask

  function automatic out_word_t mk(input logic [3:0] st, input logic [31:0] id);
    out_word_t w;
    w = '0;
    w.status = st;
    w.result_id = id;
    w.last = 1'b1;
    return w;
  endfunction

  function automatic int find_node(input logic [31:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (m_valid[i] && m_id[i] == id) return i;
    return -1;
  endfunction

  task automatic predict_table(input in_word_t w);
    int s;
    int f;
    out_word_t o;
    s = -1;
    f = -1;
    case (w.action)
      ACT_UPDATE: begin
        s = find_node(w.node_id);
        if (s < 0) begin
          for (int i = ENTRIES - 1; i >= 0; i--) if (!m_valid[i]) f = i;
          if (f < 0) begin
            pending_words.push_back(mk(ST_FULL, w.node_id));
          end else begin
            m_valid[f] = 1'b1;
            m_id[f] = w.node_id;
            m_alert_t[f] = '0;
            m_alerted[f] = 1'b0;
            s = f;
            pending_words.push_back(mk(ST_INSERTED, w.node_id));
          end
        end else begin
          pending_words.push_back(mk(ST_UPDATED, w.node_id));
        end
        if (s >= 0) begin
          m_light[s] = w.light_level;
          m_motion[s] = w.motion;
          m_role[s] = w.node_role;
          m_seen[s] = m_now;
        end
      end
      ACT_TICK: begin
        m_now = m_now + 32'd1;
        pending_words.push_back(mk(ST_TICKED, '0));
      end
      ACT_SWEEP: begin
        for (int i = 0; i < ENTRIES; i++)
          if (m_valid[i] && (m_now - m_seen[i]) > {16'd0, m_timeout}) begin
            m_valid[i] = 1'b0;
            o = mk(ST_REMOVED, m_id[i]);
            o.last = 1'b0;
            pending_words.push_back(o);
          end
        pending_words.push_back(mk(ST_SWEEPDONE, '0));
      end
      ACT_ALERT: begin
        s = find_node(w.node_id);
        if (s < 0) begin
          pending_words.push_back(mk(ST_UNKNOWN, w.node_id));
        end else if (!m_alerted[s] || (m_now - m_alert_t[s]) >= {16'd0, m_interval}) begin
          m_alerted[s] = 1'b1;
          m_alert_t[s] = m_now;
          pending_words.push_back(mk(ST_ALLOWED, w.node_id));
        end else begin
          pending_words.push_back(mk(ST_THROTTLED, w.node_id));
        end
      end
      ACT_DUMP: begin
        for (int i = 0; i < ENTRIES; i++)
          if (m_valid[i]) begin
            o = mk(ST_DUMPENT, m_id[i]);
            o.last = 1'b0;
            o.result_role = m_role[i];
            o.result_light = m_light[i];
            o.result_motion = m_motion[i];
            o.score = 20'(m_light[i]) + 20'(m_motion[i]) * 20'd2000;
            pending_words.push_back(o);
          end
        pending_words.push_back(mk(ST_DUMPDONE, '0));
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input in_word_t w, input logic has_exp, input logic [3:0] st);
    int n0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.data <= w;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n0 = pending_words.size();
    predict_table(w);
    for (int k = n0; k < pending_words.size(); k++) begin
      forced_valid.push_back(has_exp && k == pending_words.size() - 1);
      forced_status.push_back(st);
    end
    words_in++;
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [15:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom_range(65535)), val};
    pwrite <= 1'b1;
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_TIMEOUT) m_timeout = val; else m_interval = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    if (known_ids.size() != 0 && $urandom_range(9) < 8)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return $urandom;
  endfunction

  task automatic random_burst(input int unsigned count);
    in_word_t w;
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      w.node_id = pick_id();
      w.light_level = 16'($urandom);
      w.motion = 8'($urandom);
      w.node_role = 1'($urandom);
      r = $urandom_range(99);
      if (r < 35) w.action = ACT_UPDATE;
      else if (r < 60) w.action = ACT_TICK;
      else if (r < 68) w.action = ACT_SWEEP;
      else if (r < 88) w.action = ACT_ALERT;
      else if (r < 95) w.action = ACT_DUMP;
      else w.action = 3'($urandom_range(7, 5));
      if (w.action == ACT_UPDATE && known_ids.size() < 40) known_ids.push_back(w.node_id);
      if (w.action > ACT_DUMP) n--;
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk_i) begin
    out_word_t g;
    out_word_t e;
    cycles++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      g = out_if.data;
      words_out++;
      if (pending_words.size() == 0) begin
        report("unexpected word status", g.status, '0);
      end else begin
        e = pending_words.pop_front();
        if (forced_valid.pop_front() && g.status !== forced_status[0])
          report("fixed status", g.status, forced_status[0]);
        void'(forced_status.pop_front());
        if (g.status !== e.status) report("status", g.status, e.status);
        if (g.result_id !== e.result_id) report("result_id", g.result_id, e.result_id);
        if (g.result_role !== e.result_role) report("result_role", g.result_role, e.result_role);
        if (g.result_light !== e.result_light)
          report("result_light", g.result_light, e.result_light);
        if (g.result_motion !== e.result_motion)
          report("result_motion", g.result_motion, e.result_motion);
        if (g.score !== e.score) report("score", g.score, e.score);
        if (g.last !== e.last) report("last", g.last, e.last);
      end
    end
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  step_row_t directed[] = '{
    '{ACT_DUMP,   32'h0,        16'h0,    8'h0,  1'b0, 1'b1, ST_DUMPDONE},
    '{ACT_ALERT,  32'hFFFFFFFF, 16'h0,    8'h0,  1'b0, 1'b1, ST_UNKNOWN},
    '{ACT_SWEEP,  32'h0,        16'h0,    8'h0,  1'b0, 1'b1, ST_SWEEPDONE},
    '{ACT_UPDATE, 32'h0,        16'h0,    8'h0,  1'b0, 1'b1, ST_INSERTED},
    '{ACT_UPDATE, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, ST_INSERTED},
    '{ACT_UPDATE, 32'hFFFFFFFF, 16'h1234, 8'h80, 1'b0, 1'b1, ST_UPDATED},
    '{ACT_UPDATE, 32'hA5A5A5A5, 16'h5A5A, 8'h55, 1'b1, 1'b1, ST_INSERTED},
    '{ACT_ALERT,  32'h0,        16'h0,    8'h0,  1'b0, 1'b1, ST_ALLOWED},
    '{ACT_ALERT,  32'h0,        16'h0,    8'h0,  1'b0, 1'b1, ST_THROTTLED},
    '{ACT_TICK,   32'h0,        16'h0,    8'h0,  1'b0, 1'b1, ST_TICKED},
    '{ACT_ALERT,  32'hFFFFFFFF, 16'h0,    8'h0,  1'b0, 1'b1, ST_ALLOWED},
    '{ACT_DUMP,   32'h0,        16'h0,    8'h0,  1'b0, 1'b0, ST_DUMPDONE},
    '{3'd5,       32'h1,        16'h1,    8'h1,  1'b1, 1'b0, ST_UPDATED},
    '{3'd6,       32'h2,        16'h2,    8'h2,  1'b0, 1'b0, ST_UPDATED},
    '{3'd7,       32'h3,        16'h3,    8'h3,  1'b1, 1'b0, ST_UPDATED},
    '{ACT_UPDATE, 32'h0,        16'h7,    8'h1,  1'b1, 1'b1, ST_UPDATED},
    '{ACT_SWEEP,  32'h0,        16'h0,    8'h0,  1'b0, 1'b0, ST_SWEEPDONE}
  };

  initial begin
    in_word_t w;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    m_timeout = 16'd30;
    m_interval = 16'd10;
    m_now = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      m_valid[i] = 1'b0;
      m_id[i] = '0; m_role[i] = '0; m_light[i] = '0; m_motion[i] = '0;
      m_seen[i] = '0; m_alert_t[i] = '0; m_alerted[i] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[k]) begin
      w.action = directed[k].action;
      w.node_id = directed[k].node_id;
      w.light_level = directed[k].light;
      w.motion = directed[k].motion;
      w.node_role = directed[k].role;
      send_word(w, directed[k].has_exp, directed[k].exp_status);
    end
    drain();

    // fill the table past capacity, then age and sweep at zero timeout
    apb_write(REG_TIMEOUT, 16'd0);
    apb_write(REG_INTERVAL, 16'd0);
    for (int i = 0; i < ENTRIES + 2; i++) begin
      w = '0;
      w.action = ACT_UPDATE;
      w.node_id = 32'h100 + i;
      w.motion = 8'(i);
      w.light_level = 16'(i * 37);
      send_word(w, i >= ENTRIES - 3, (i >= ENTRIES - 3) ? ST_FULL : ST_INSERTED);
    end
    w = '0;
    w.action = ACT_DUMP; send_word(w, 1'b0, '0);
    w.action = ACT_ALERT; w.node_id = 32'h100; send_word(w, 1'b0, '0);
    send_word(w, 1'b1, ST_ALLOWED);
    w.action = ACT_TICK; send_word(w, 1'b0, '0);
    w.action = ACT_SWEEP; send_word(w, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 57; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 57; end
        default: begin in_idle_pct = 25; out_stall_pct = 25; end
      endcase
      case (phase)
        0: begin apb_write(REG_TIMEOUT, 16'hFFFF); apb_write(REG_INTERVAL, 16'hFFFF); end
        1: begin apb_write(REG_TIMEOUT, 16'd5); apb_write(REG_INTERVAL, 16'd3); end
        2: begin apb_write(REG_TIMEOUT, 16'd30); apb_write(REG_INTERVAL, 16'd10); end
        default: begin
          apb_write(REG_TIMEOUT, 16'($urandom_range(12)));
          apb_write(REG_INTERVAL, 16'($urandom_range(6)));
        end
      endcase
      random_burst(52);
      drain();
    end

    $display("covered %0d input words and %0d result words over four handshake phases",
             words_in, words_out);
    $display("register settings from zero to full scale, table full and aging sweeps");
    if (errors == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/ntar_pkg.sv
design/ntar_stream_if.sv
design/ntar_ctrl.sv
design/ntar_datapath.sv
design/node_table_with_aging_and_rate_limit.sv
bench/node_table_with_aging_and_rate_limit_tb.sv
